// ===== src/sgm_pkg.sv =====
// Shared constants and types for the Sobel gradient magnitude block.
package sgm_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = 22;
	localparam int GRAD_W     = 11;
	localparam int MAG_W      = 8;
	localparam int SAT_MAX    = 255;
	localparam int MIN_SIZE   = 3;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// result queue between the window front end and the magnitude stage
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic signed [GRAD_W-1:0] hs;
		logic signed [GRAD_W-1:0] vs;
		logic [IDX_W-1:0]         idx;
	} grad_t;

endpackage

// ===== src/sobel_gradient_magnitude.sv =====
// Sobel 3x3 gradient magnitude over a raster pixel stream.
// Throughput: one pixel per cycle while in_ready is high; a result goes through the
// stage-1 and stage-2 registers and the result queue to the output register.
// in_ready drops once the 4-entry result queue plus the two front stages hold 4 items.
// Reset: frame counters cleared, size registers 640 x 480, line memory not cleared
// (it is written within a frame before any emitted result depends on it).
module sobel_gradient_magnitude #(
	parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sgm_pkg::PIX_W-1:0]     pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sgm_pkg::MAG_W-1:0]     magnitude,
	output logic [sgm_pkg::IDX_W-1:0]     out_index,
	input  logic                          cfg_we,
	input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0]     cfg_wdata
);

	logic                        push, pop, avail;
	sgm_pkg::grad_t              push_data, head;
	logic [sgm_pkg::Q_CNT_W-1:0] q_count;

	sgm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	sgm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.avail     (avail),
		.head      (head),
		.count     (q_count)
	);

	sgm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.magnitude (magnitude),
		.out_index (out_index)
	);

endmodule

// ===== src/sgm_front.sv =====
// Front end: pixel intake, frame counters, line memory, 3x3 window and Sobel sums.
module sgm_front #(
	parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sgm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sgm_pkg::PIX_W-1:0]      pixel,
	input  logic                           cfg_we,
	input  logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [sgm_pkg::Q_CNT_W-1:0]    q_count,
	output logic                           push,
	output sgm_pkg::grad_t                 push_data
);

	localparam int PW    = sgm_pkg::PIX_W;
	localparam int GW    = sgm_pkg::GRAD_W;
	localparam int IW    = sgm_pkg::IDX_W;
	localparam int CNTW  = sgm_pkg::Q_CNT_W;
	localparam int MW    = 2 * PW;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int EWW   = $clog2(MAX_WIDTH + 1);
	localparam int EHW   = $clog2(MAX_HEIGHT + 1);
	localparam int XW0   = (EWW > EHW) ? EWW : EHW;
	localparam int XW    = (XW0 > sgm_pkg::CFG_W) ? XW0 : sgm_pkg::CFG_W;

	logic [sgm_pkg::CFG_W-1:0] width_q, height_q;
	logic [XW-1:0]             w_ext, h_ext;
	logic [EWW-1:0]            eff_w;
	logic [EHW-1:0]            eff_h;

	logic [IW-1:0] p_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          col_last, row_last, emit, accept;
	logic [IW-1:0] span, idx_now;
	logic [CNTW-1:0] occ;

	// line memory word: {pixel one row back, pixel two rows back}
	logic [MW-1:0] line_mem [MAX_WIDTH];
	logic [MW-1:0] rd_s1;

	logic          acc_s1, emit_s1;
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] addr_s1;
	logic [IW-1:0] idx_s1;

	logic [PW-1:0] r0_1_q, r0_2_q, r1_1_q, r1_2_q, r2_1_q, r2_2_q;

	logic signed [GW-1:0] a00, a01, a02, a10, a12, a20, a21, a22;
	logic signed [GW-1:0] hs, vs;

	logic                 push_s2;
	logic signed [GW-1:0] hs_s2, vs_s2;
	logic [IW-1:0]        idx_s2;

	always_comb begin
		w_ext = XW'(width_q);
		h_ext = XW'(height_q);
		if (w_ext < XW'(sgm_pkg::MIN_SIZE)) begin
			eff_w = EWW'(sgm_pkg::MIN_SIZE);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			eff_w = EWW'(MAX_WIDTH);
		end else begin
			eff_w = EWW'(w_ext);
		end
		if (h_ext < XW'(sgm_pkg::MIN_SIZE)) begin
			eff_h = EHW'(sgm_pkg::MIN_SIZE);
		end else if (h_ext > XW'(MAX_HEIGHT)) begin
			eff_h = EHW'(MAX_HEIGHT);
		end else begin
			eff_h = EHW'(h_ext);
		end
	end

	assign col_last = (EWW'(col_q) == eff_w - EWW'(1));
	assign row_last = (EHW'(row_q) == eff_h - EHW'(1));
	// window complete once two rows plus two pixels are in
	assign emit     = (row_q > RW'(2)) || ((row_q == RW'(2)) && (col_q >= CW'(2)));
	assign span     = (IW'(eff_w) << 1) + IW'(1);
	assign idx_now  = p_q - span;

	// reserve queue room for every item still in the pipe
	assign occ      = q_count + CNTW'(acc_s1) + CNTW'(push_s2);
	assign in_ready = (occ < CNTW'(sgm_pkg::Q_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sgm_pkg::WIDTH_RESET;
			height_q <= sgm_pkg::HEIGHT_RESET;
			p_q      <= '0;
			col_q    <= '0;
			row_q    <= '0;
			acc_s1   <= 1'b0;
			push_s2  <= 1'b0;
		end else begin
			acc_s1  <= accept;
			push_s2 <= acc_s1 && emit_s1;
			if (cfg_we) begin
				if (cfg_index == sgm_pkg::REG_IMAGE_WIDTH) begin
					width_q <= cfg_wdata;
					p_q     <= '0;
					col_q   <= '0;
					row_q   <= '0;
				end else if (cfg_index == sgm_pkg::REG_IMAGE_HEIGHT) begin
					height_q <= cfg_wdata;
					p_q      <= '0;
					col_q    <= '0;
					row_q    <= '0;
				end
			end else if (accept) begin
				if (col_last && row_last) begin
					p_q   <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					p_q <= p_q + IW'(1);
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
		end
	end

	// line memory: read at intake, write back in the following cycle with the shifted pair
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
		if (acc_s1) begin
			line_mem[addr_s1] <= {pix_s1, rd_s1[MW-1:PW]};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixel;
			addr_s1 <= col_q;
			emit_s1 <= emit;
			idx_s1  <= idx_now;
		end
		if (acc_s1) begin
			r0_1_q <= pix_s1;
			r0_2_q <= r0_1_q;
			r1_1_q <= rd_s1[MW-1:PW];
			r1_2_q <= r1_1_q;
			r2_1_q <= rd_s1[PW-1:0];
			r2_2_q <= r2_1_q;
			hs_s2  <= hs;
			vs_s2  <= vs;
			idx_s2 <= idx_s1;
		end
	end

	always_comb begin
		a00 = $signed(GW'(r2_2_q));
		a01 = $signed(GW'(r2_1_q));
		a02 = $signed(GW'(rd_s1[PW-1:0]));
		a10 = $signed(GW'(r1_2_q));
		a12 = $signed(GW'(rd_s1[MW-1:PW]));
		a20 = $signed(GW'(r0_2_q));
		a21 = $signed(GW'(r0_1_q));
		a22 = $signed(GW'(pix_s1));
		hs  = a20 + (a21 <<< 1) + a22 - a00 - (a01 <<< 1) - a02;
		vs  = a02 + (a12 <<< 1) + a22 - a00 - (a10 <<< 1) - a20;
	end

	assign push          = push_s2;
	assign push_data.hs  = hs_s2;
	assign push_data.vs  = vs_s2;
	assign push_data.idx = idx_s2;

endmodule

// ===== src/sgm_queue.sv =====
// Short queue of gradient sums between the front end and the magnitude stage.
module sgm_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  sgm_pkg::grad_t              push_data,
	input  logic                        pop,
	output logic                        avail,
	output sgm_pkg::grad_t              head,
	output logic [sgm_pkg::Q_CNT_W-1:0] count
);

	localparam int PTW = sgm_pkg::Q_PTR_W;
	localparam int CTW = sgm_pkg::Q_CNT_W;

	sgm_pkg::grad_t entries_q [sgm_pkg::Q_DEPTH];
	logic [PTW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CTW-1:0] count_q;

	assign avail = (count_q != '0);
	assign head  = entries_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTW'(sgm_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTW'(sgm_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/sgm_back.sv =====
// Back end: |H|+|V| with saturation into the output register.
module sgm_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      avail,
	input  sgm_pkg::grad_t            head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sgm_pkg::MAG_W-1:0] magnitude,
	output logic [sgm_pkg::IDX_W-1:0] out_index
);

	localparam int GW = sgm_pkg::GRAD_W;
	localparam int SW = GW + 1;

	logic [GW-1:0] abs_h, abs_v;
	logic [SW-1:0] sum;
	logic [sgm_pkg::MAG_W-1:0] mag;

	logic                      out_valid_q;
	logic [sgm_pkg::MAG_W-1:0] magnitude_q;
	logic [sgm_pkg::IDX_W-1:0] out_index_q;

	always_comb begin
		abs_h = head.hs[GW-1] ? GW'(-head.hs) : GW'(head.hs);
		abs_v = head.vs[GW-1] ? GW'(-head.vs) : GW'(head.vs);
		sum   = SW'(abs_h) + SW'(abs_v);
		mag   = (sum > SW'(sgm_pkg::SAT_MAX)) ? sgm_pkg::MAG_W'(sgm_pkg::SAT_MAX)
		                                      : sgm_pkg::MAG_W'(sum);
	end

	assign pop = avail && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			magnitude_q <= mag;
			out_index_q <= head.idx;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = magnitude_q;
	assign out_index = out_index_q;

endmodule
